>>> hw/rtl/ptrq_pkg.sv
// shared types, codes and helpers for the point table with radius query
package ptrq_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_NAME_BYTES  = 8;

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_SEARCH = 3'd1;
    localparam logic [2:0] FUNC_MODIFY = 3'd2;
    localparam logic [2:0] FUNC_DELETE = 3'd3;
    localparam logic [2:0] FUNC_RADIUS = 3'd4;
    localparam logic [2:0] FUNC_DUMP   = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [63:0]        key_name;
        logic [63:0]        new_name;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        radius;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        out_name;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

    // keep bytes up to the first zero byte and within nbytes
    function automatic logic [63:0] canon_name(input logic [63:0] v, input int nbytes);
        logic [63:0] r;
        logic        alive;
        r     = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= nbytes || v[8*i +: 8] == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        return d[16] ? 16'(-d) : 16'(d);
    endfunction

    function automatic out_item_t make_item(input logic [1:0] status,
                                            input logic [63:0] name,
                                            input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic last);
        out_item_t it;
        it.status   = status;
        it.out_name = name;
        it.out_x    = x;
        it.out_y    = y;
        it.last     = last;
        return it;
    endfunction

endpackage

>>> hw/rtl/ptrq_store.sv
// entry memory: one write port, one registered read port
module ptrq_store #(
    parameter int DEPTH = ptrq_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = 8 * ptrq_pkg::DEF_NAME_BYTES + 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ptrq_sq.sv
// shared squaring unit with registered product
module ptrq_sq (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] a,
    output logic [31:0] p
);

    logic [31:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= 32'(a) * 32'(a);
        end
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/ptrq_ctrl.sv
// sequencer: table scan, insert, modify, delete compaction and radius test
module ptrq_ctrl #(
    parameter int TABLE_DEPTH = ptrq_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_BYTES  = ptrq_pkg::DEF_NAME_BYTES,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int NB = 8 * NAME_BYTES,
    localparam int EW = NB + 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ptrq_pkg::in_item_t in_item,
    output logic               in_ready,
    input  logic               out_free,
    output ptrq_pkg::emit_t    emit,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [EW-1:0]      mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  logic [EW-1:0]      mem_rdata,
    output logic               sq_en,
    output logic [15:0]        sq_a,
    input  logic [31:0]        sq_p
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_RSQ   = 4'd2;
    localparam logic [3:0] S_RSQW  = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_EV    = 4'd6;
    localparam logic [3:0] S_MY    = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_DRD   = 4'd12;
    localparam logic [3:0] S_DWR   = 4'd13;

    logic [3:0]         state_reg, state_next;
    logic [3:0]         ret_reg, ret_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [2:0]         func_reg, func_next;
    logic [NB-1:0]      key_reg, key_next;
    logic [NB-1:0]      nnew_reg, nnew_next;
    logic signed [15:0] px_reg, px_next;
    logic signed [15:0] py_reg, py_next;
    logic [15:0]        rad_reg, rad_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [31:0]        r2_reg, r2_next;
    logic [31:0]        sqx_reg, sqx_next;
    logic [NB-1:0]      ent_name_reg, ent_name_next;
    logic signed [15:0] ent_x_reg, ent_x_next;
    logic signed [15:0] ent_y_reg, ent_y_next;
    logic [NB-1:0]      pend_name_reg, pend_name_next;
    logic signed [15:0] pend_x_reg, pend_x_next;
    logic signed [15:0] pend_y_reg, pend_y_next;
    ptrq_pkg::out_item_t em_reg, em_next;

    logic [63:0]        key_canon;
    logic [63:0]        nnew_canon;
    logic [NB-1:0]      rd_name;
    logic signed [15:0] rd_x;
    logic signed [15:0] rd_y;
    logic [32:0]        dsq;

    assign key_canon  = ptrq_pkg::canon_name(in_item.key_name, NAME_BYTES);
    assign nnew_canon = ptrq_pkg::canon_name(in_item.new_name, NAME_BYTES);
    assign rd_name    = mem_rdata[EW-1:32];
    assign rd_x       = mem_rdata[31:16];
    assign rd_y       = mem_rdata[15:0];
    assign dsq        = {1'b0, sqx_reg} + {1'b0, sq_p};
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        nnew_next       = nnew_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        rad_next        = rad_reg;
        slot_next       = slot_reg;
        r2_next         = r2_reg;
        sqx_next        = sqx_reg;
        ent_name_next   = ent_name_reg;
        ent_x_next      = ent_x_reg;
        ent_y_next      = ent_y_reg;
        pend_name_next  = pend_name_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        em_next         = em_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = {nnew_reg, px_reg, py_reg};
        mem_re          = 1'b0;
        mem_raddr       = slot_reg;
        sq_en           = 1'b0;
        sq_a            = rad_reg;
        emit.valid      = 1'b0;
        emit.item       = em_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = in_item.func;
                    key_next   = key_canon[NB-1:0];
                    nnew_next  = nnew_canon[NB-1:0];
                    px_next    = in_item.pos_x;
                    py_next    = in_item.pos_y;
                    rad_next   = in_item.radius;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                pend_valid_next = 1'b0;
                ret_next        = S_IDLE;
                case (func_reg)
                    ptrq_pkg::FUNC_INSERT:
                    begin
                        if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            em_next = ptrq_pkg::make_item(ptrq_pkg::STATUS_FULL, '0,
                                                          '0, '0, 1'b1);
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = {key_reg, px_reg, py_reg};
                            count_next = count_reg + 1'b1;
                            em_next    = ptrq_pkg::make_item(ptrq_pkg::STATUS_OK,
                                                             64'(key_reg), px_reg,
                                                             py_reg, 1'b1);
                        end
                        state_next = S_EMIT;
                    end
                    ptrq_pkg::FUNC_SEARCH, ptrq_pkg::FUNC_MODIFY,
                    ptrq_pkg::FUNC_DELETE, ptrq_pkg::FUNC_DUMP:
                    begin
                        state_next = S_START;
                    end
                    ptrq_pkg::FUNC_RADIUS:
                    begin
                        state_next = S_RSQ;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RSQ:
            begin
                sq_en      = 1'b1;
                sq_a       = rad_reg;
                state_next = S_RSQW;
            end
            S_RSQW:
            begin
                r2_next    = sq_p;
                state_next = S_START;
            end
            S_START:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    slot_next  = AW'(count_reg - 1'b1);
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = slot_reg;
                state_next = S_EV;
            end
            S_EV:
            begin
                ent_name_next = rd_name;
                ent_x_next    = rd_x;
                ent_y_next    = rd_y;
                case (func_reg)
                    ptrq_pkg::FUNC_DUMP:
                    begin
                        em_next    = ptrq_pkg::make_item(ptrq_pkg::STATUS_OK,
                                                         64'(rd_name), rd_x, rd_y,
                                                         slot_reg == '0);
                        ret_next   = S_NEXT;
                        state_next = S_EMIT;
                    end
                    ptrq_pkg::FUNC_RADIUS:
                    begin
                        sq_en      = 1'b1;
                        sq_a       = ptrq_pkg::abs_diff(px_reg, rd_x);
                        state_next = S_MY;
                    end
                    default:
                    begin
                        if (rd_name == key_reg)
                        begin
                            if (func_reg == ptrq_pkg::FUNC_MODIFY)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_reg;
                                mem_wdata = {nnew_reg, px_reg, py_reg};
                                em_next   = ptrq_pkg::make_item(ptrq_pkg::STATUS_OK,
                                                                64'(nnew_reg), px_reg,
                                                                py_reg, 1'b1);
                            end
                            else
                            begin
                                em_next = ptrq_pkg::make_item(ptrq_pkg::STATUS_OK,
                                                              64'(rd_name), rd_x, rd_y,
                                                              1'b1);
                            end
                            ret_next   = (func_reg == ptrq_pkg::FUNC_DELETE) ? S_DRD
                                                                              : S_IDLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_NEXT;
                        end
                    end
                endcase
            end
            S_MY:
            begin
                sqx_next   = sq_p;
                sq_en      = 1'b1;
                sq_a       = ptrq_pkg::abs_diff(py_reg, ent_y_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_NEXT;
                if (dsq <= {1'b0, r2_reg})
                begin
                    if (pend_valid_reg)
                    begin
                        em_next    = ptrq_pkg::make_item(ptrq_pkg::STATUS_OK,
                                                        64'(pend_name_reg), pend_x_reg,
                                                        pend_y_reg, 1'b0);
                        ret_next   = S_NEXT;
                        state_next = S_EMIT;
                    end
                    pend_valid_next = 1'b1;
                    pend_name_next  = ent_name_reg;
                    pend_x_next     = ent_x_reg;
                    pend_y_next     = ent_y_reg;
                end
            end
            S_NEXT:
            begin
                if (slot_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    slot_next  = slot_reg - 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                ret_next   = S_IDLE;
                state_next = S_EMIT;
                case (func_reg)
                    ptrq_pkg::FUNC_DUMP:
                    begin
                        state_next = S_IDLE;
                    end
                    ptrq_pkg::FUNC_RADIUS:
                    begin
                        pend_valid_next = 1'b0;
                        if (pend_valid_reg)
                        begin
                            em_next = ptrq_pkg::make_item(ptrq_pkg::STATUS_OK,
                                                          64'(pend_name_reg), pend_x_reg,
                                                          pend_y_reg, 1'b1);
                        end
                        else
                        begin
                            em_next = ptrq_pkg::make_item(ptrq_pkg::STATUS_NOT_FOUND,
                                                          '0, '0, '0, 1'b1);
                        end
                    end
                    default:
                    begin
                        em_next = ptrq_pkg::make_item(ptrq_pkg::STATUS_NOT_FOUND,
                                                      '0, '0, '0, 1'b1);
                    end
                endcase
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    state_next = ret_reg;
                end
            end
            S_DRD:
            begin
                if ((CW'(slot_reg) + 1'b1) == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = slot_reg + 1'b1;
                    state_next = S_DWR;
                end
            end
            S_DWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_reg;
                mem_wdata  = mem_rdata;
                slot_next  = slot_reg + 1'b1;
                state_next = S_DRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        nnew_reg      <= nnew_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        rad_reg       <= rad_next;
        slot_reg      <= slot_next;
        r2_reg        <= r2_next;
        sqx_reg       <= sqx_next;
        ent_name_reg  <= ent_name_next;
        ent_x_reg     <= ent_x_next;
        ent_y_reg     <= ent_y_next;
        pend_name_reg <= pend_name_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        em_reg        <= em_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == $past(count_reg) + 1'b1 ||
                                 count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_compact_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DWR |-> (CW'(slot_reg) + 1'b1) < count_reg)
        else $error("compaction copy outside live entries");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DISP)
        else $error("accepted transfer not dispatched");
`endif

endmodule

>>> hw/rtl/point_table_with_radius_query.sv
// top level of the point table with radius query
// A table of up to TABLE_DEPTH named points kept newest first. One operation is taken at a
// time and in_ready stays low until the operation is finished, compaction after a delete
// included. Entries live in a memory with one write port and one registered read port,
// walked newest to oldest one entry at a time, and the radius test runs on one shared
// 16-bit squaring unit. After a delete hit, each newer entry is moved down one slot to close
// the gap. The sequencer waits in its emit state while the output register is full and
// out_ready is low.
module point_table_with_radius_query #(
    parameter int TABLE_DEPTH = ptrq_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_BYTES  = ptrq_pkg::DEF_NAME_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ptrq_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ptrq_pkg::out_item_t out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = 8 * NAME_BYTES + 32;

    logic                out_valid_reg;
    ptrq_pkg::out_item_t out_item_reg;
    logic                out_free;
    ptrq_pkg::emit_t     emit;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [EW-1:0]       mem_rdata;
    logic                sq_en;
    logic [15:0]         sq_a;
    logic [31:0]         sq_p;

    assign out_free = !out_valid_reg || out_ready;

    ptrq_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_item  (in_item),
        .in_ready (in_ready),
        .out_free (out_free),
        .emit     (emit),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata),
        .sq_en    (sq_en),
        .sq_a     (sq_a),
        .sq_p     (sq_p)
    );

    ptrq_store #(
        .DEPTH(TABLE_DEPTH),
        .WIDTH(EW)
    ) u_store (
        .clk    (clk),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_en  (mem_re),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

    ptrq_sq u_sq (
        .clk(clk),
        .en (sq_en),
        .a  (sq_a),
        .p  (sq_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_item_reg <= emit.item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
